>>> rtl/olb_pkg.sv
package olb_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] ACT_INS_FRONT = 2'd0;
  localparam logic [1:0] ACT_INS_BACK  = 2'd1;
  localparam logic [1:0] ACT_DELETE    = 2'd2;
  localparam logic [1:0] ACT_DUMP      = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_FRONT,
    OP_BACK,
    OP_DEL
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_DUMP
  } bk_state_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         pos;
    logic [CNT_W-1:0]         new_count;
    logic [1:0]               status;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_wr_t;

endpackage

>>> rtl/olb_if.sv
interface olb_in_if import olb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source(output valid, action, value, position, input ready);
  modport sink(input valid, action, value, position, output ready);
endinterface

interface olb_out_if import olb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] element;
  logic                     is_empty;
  logic                     last;
  logic [1:0]               status;

  modport source(output valid, element, is_empty, last, status, input ready);
  modport sink(input valid, element, is_empty, last, status, output ready);
endinterface

>>> rtl/olb_front.sv
module olb_front import olb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  olb_in_if.sink       in_ch,
  input  logic         q_full,
  output cmd_wr_t      q_wr
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  cmd_t             cmd;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // count tracks what the back end will hold once this item is applied
  always_comb begin
    cmd.op        = OP_NONE;
    cmd.value     = in_ch.value;
    cmd.pos       = IDX_W'(in_ch.position);
    cmd.status    = ST_DONE;
    cnt_nxt       = cnt_r;
    case (in_ch.action)
      ACT_INS_FRONT, ACT_INS_BACK: begin
        if (cnt_r == CNT_W'(CAPACITY)) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.op  = (in_ch.action == ACT_INS_FRONT) ? OP_FRONT : OP_BACK;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ACT_DELETE: begin
        if (CMP_W'(in_ch.position) >= CMP_W'(cnt_r)) begin
          cmd.status = ST_ABSENT;
        end else begin
          cmd.op  = OP_DEL;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    cmd.new_count = cnt_nxt;
  end

  assign q_wr.valid = accept;
  assign q_wr.cmd   = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/olb_fifo.sv
module olb_fifo import olb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_wr_t wr,
  output logic    full,
  input  logic    rd,
  output cmd_t    rd_cmd,
  output logic    empty
);

  cmd_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full   = (cnt_r == 2'd2);
  assign empty  = (cnt_r == 2'd0);
  assign rd_cmd = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      slot_r[wp_r] <= wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr.valid) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr.valid} - {1'b0, rd};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr.valid && full && !rd)) else $error("queue write while full");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count out of range");

endmodule

>>> rtl/olb_back.sv
module olb_back import olb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cmd_t     q_cmd,
  input  logic     q_empty,
  output logic     q_rd,
  olb_out_if.source out_ch
);

  bk_state_t                state_r, state_nxt;
  logic signed [DATA_W-1:0] cells_r [CAPACITY];
  logic [CNT_W-1:0]         cnt_r;
  logic [IDX_W-1:0]         idx_r;
  logic [1:0]               status_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_element_r;
  logic                     out_is_empty_r;
  logic                     out_last_r;
  logic [1:0]               out_status_r;

  logic emit;
  logic list_empty;
  logic final_elem;

  assign list_empty = (cnt_r == '0);
  assign final_elem = list_empty || ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);

  always_comb begin
    state_nxt = state_r;
    q_rd      = 1'b0;
    emit      = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_rd      = 1'b1;
          state_nxt = BK_DUMP;
        end
      end
      BK_DUMP: begin
        if (!out_valid_r || out_ch.ready) begin
          emit = 1'b1;
          if (final_elem) state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // each cell looks only at its neighbors; all cells apply the op together as the command is read
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (q_rd) begin
        case (q_cmd.op)
          OP_FRONT: begin
            if (g == 0) cells_r[g] <= q_cmd.value;
            else        cells_r[g] <= cells_r[(g > 0) ? g - 1 : 0];
          end
          OP_BACK: begin
            if (IDX_W'(cnt_r) == IDX_W'(g)) cells_r[g] <= q_cmd.value;
          end
          OP_DEL: begin
            if (g < CAPACITY - 1 && IDX_W'(g) >= q_cmd.pos)
              cells_r[g] <= cells_r[(g < CAPACITY - 1) ? g + 1 : g];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (q_rd) begin
      cnt_r <= q_cmd.new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      status_r <= q_cmd.status;
      idx_r    <= '0;
    end else if (emit) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_element_r  <= list_empty ? '0 : cells_r[idx_r];
      out_is_empty_r <= list_empty;
      out_last_r     <= final_elem;
      out_status_r   <= status_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.element  = out_element_r;
  assign out_ch.is_empty = out_is_empty_r;
  assign out_ch.last     = out_last_r;
  assign out_ch.status   = out_status_r;

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY)) else $error("element count above capacity");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_is_empty_r |-> out_last_r && out_element_r == '0)
    else $error("empty dump not a single zero item");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit && final_elem |=> state_r == BK_IDLE)
    else $error("dump did not end after final item");

endmodule

>>> rtl/ordered_list_buffer.sv
// A request's result items pass through the command queue, the back end's command
//   read and the output register; each dump is paced by the output handshake.
// A 2-entry command queue lets requests be accepted while a dump is running.
// Reset (rst_n low, synchronous): list emptied, queue and output cleared.
module ordered_list_buffer import olb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  olb_in_if.sink    in_ch,
  olb_out_if.source out_ch
);

  cmd_wr_t q_wr;
  logic    q_full;
  logic    q_rd;
  logic    q_empty;
  cmd_t    q_cmd;

  olb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  olb_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .full   (q_full),
    .rd     (q_rd),
    .rd_cmd (q_cmd),
    .empty  (q_empty)
  );

  olb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_cmd   (q_cmd),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .out_ch  (out_ch)
  );

endmodule

>>> bench/olb_list_checker.sv
`timescale 1ns / 100ps

module olb_list_checker import olb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  olb_in_if    in_ch,
  olb_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   list_size
);

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic                     is_empty;
    logic                     last;
    logic [1:0]               status;
  } dump_entry_t;

  logic signed [DATA_W-1:0] list_q[$];
  dump_entry_t              expected_dump[$];

  int errors        = 0;
  int pending_count = 0;
  int size_now      = 0;

  assign fail_count = errors;
  assign pending    = pending_count;
  assign list_size  = size_now;

  task automatic report_mismatch(input string what);
    $display("%0t ns olb_list_checker: %s", $time, what);
    errors++;
  endtask

  // Apply one request to the predicted list, then queue its full dump.
  task automatic apply_request(input logic [1:0] action,
                               input logic signed [DATA_W-1:0] value,
                               input logic [POS_W-1:0] position);
    logic [1:0]  status;
    dump_entry_t entry;
    status = ST_DONE;
    case (action)
      ACT_INS_FRONT, ACT_INS_BACK: begin
        if (list_q.size() >= CAPACITY) status = ST_FULL;
        else if (action == ACT_INS_FRONT) list_q.push_front(value);
        else list_q.push_back(value);
      end
      ACT_DELETE: begin
        if (int'(position) >= list_q.size()) status = ST_ABSENT;
        else list_q.delete(int'(position));
      end
      ACT_DUMP: ;
      default: ;
    endcase
    if (list_q.size() == 0) begin
      entry.element  = '0;
      entry.is_empty = 1'b1;
      entry.last     = 1'b1;
      entry.status   = status;
      expected_dump.push_back(entry);
    end else begin
      foreach (list_q[i]) begin
        entry.element  = list_q[i];
        entry.is_empty = 1'b0;
        entry.last     = (i == list_q.size() - 1);
        entry.status   = status;
        expected_dump.push_back(entry);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    dump_entry_t want;
    if (!rst_n) begin
      list_q.delete();
      expected_dump.delete();
    end else begin
      // results come from older items, so pop before pushing this edge's item
      if (out_ch.valid && out_ch.ready) begin
        if (expected_dump.size() == 0) begin
          report_mismatch($sformatf("unexpected item element=%0d empty=%0b last=%0b status=%0d",
                                    out_ch.element, out_ch.is_empty, out_ch.last,
                                    out_ch.status));
        end else begin
          want = expected_dump.pop_front();
          if (out_ch.element !== want.element || out_ch.is_empty !== want.is_empty ||
              out_ch.last !== want.last || out_ch.status !== want.status) begin
            report_mismatch($sformatf(
              "got element=%0d empty=%0b last=%0b status=%0d, want %0d/%0b/%0b/%0d",
              out_ch.element, out_ch.is_empty, out_ch.last, out_ch.status,
              want.element, want.is_empty, want.last, want.status));
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        apply_request(in_ch.action, in_ch.value, in_ch.position);
    end
    pending_count = expected_dump.size();
    size_now      = list_q.size();
  end

endmodule

>>> bench/tb_ordered_list_buffer.sv
`timescale 1ns / 100ps

module tb_ordered_list_buffer;
  import olb_pkg::*;

  localparam int RANDOM_ITEMS = 390;
  localparam int PHASE_LEN    = 45;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   steady = 1'b0;  // set: neither side idles

  int fail_count;
  int pending;
  int list_size;

  always #5 clk = ~clk;

  olb_in_if  in_ch();
  olb_out_if out_ch();

  ordered_list_buffer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  olb_list_checker list_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .list_size  (list_size)
  );

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = steady ? 1'b1 : ($urandom_range(99) >= 17);
    end
  end

  task automatic send_item(input logic [1:0] action,
                           input logic signed [DATA_W-1:0] value,
                           input logic [POS_W-1:0] position);
    while (!steady && $urandom_range(99) < 17) begin
      in_ch.valid    = 1'b0;
      in_ch.action   = 2'($urandom);
      in_ch.value    = $urandom;
      in_ch.position = POS_W'($urandom);
      @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.action   = action;
    in_ch.value    = value;
    in_ch.position = position;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(99);
    if (list_size == 0) return (r < 50) ? '0 : POS_W'($urandom);
    if (r < 75) return POS_W'($urandom_range(list_size - 1));
    if (r < 82) return POS_W'(list_size - 1);
    if (r < 88) return '0;
    return POS_W'($urandom);
  endfunction

  initial begin
    int phase;
    int roll;
    logic [1:0] act;

    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_DUMP;
    in_ch.value    = '0;
    in_ch.position = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // empty list: dump and deletes that find nothing
    send_item(ACT_DUMP,      32'sh0bad_cafe, 6'd17);
    send_item(ACT_DELETE,    $urandom,       6'd0);
    send_item(ACT_DELETE,    $urandom,       6'd63);
    send_item(ACT_INS_FRONT, 32'sh8000_0000, 6'd63);
    send_item(ACT_INS_BACK,  32'sh7fff_ffff, 6'd0);
    send_item(ACT_INS_FRONT, '0,             6'd42);
    send_item(ACT_INS_BACK,  -32'sd1,        6'd21);
    send_item(ACT_DUMP,      32'sh5a5a_5a5a, 6'd63);
    send_item(ACT_DELETE,    $urandom,       6'd4);
    // delete at the back, then check the new back by appending
    send_item(ACT_DELETE,    $urandom,       6'd3);
    send_item(ACT_INS_BACK,  32'sd5,         6'd0);
    // delete the front until empty, then the tail must still be right
    send_item(ACT_DELETE,    $urandom,       6'd0);
    send_item(ACT_DELETE,    $urandom,       6'd0);
    send_item(ACT_DELETE,    $urandom,       6'd0);
    send_item(ACT_DELETE,    $urandom,       6'd0);
    send_item(ACT_INS_BACK,  32'sh1234_5678, 6'd0);
    send_item(ACT_INS_FRONT, 32'sh5555_aaaa, 6'd0);
    send_item(ACT_DELETE,    $urandom,       6'd1);
    send_item(ACT_DELETE,    $urandom,       6'd0);
    send_item(ACT_INS_FRONT, 32'sd7,         6'd0);
    send_item(ACT_DELETE,    $urandom,       6'd0);
    send_item(ACT_INS_BACK,  32'sd9,         6'd0);
    send_item(ACT_DUMP,      $urandom,       6'd0);

    drain_results();

    // fill to capacity, then push against the full store
    while (list_size < CAPACITY)
      send_item($urandom_range(1) ? ACT_INS_BACK : ACT_INS_FRONT, pick_value(),
                POS_W'($urandom));
    send_item(ACT_INS_FRONT, pick_value(), POS_W'($urandom));
    send_item(ACT_INS_BACK,  pick_value(), POS_W'($urandom));
    send_item(ACT_DELETE,    $urandom,     POS_W'(CAPACITY));
    send_item(ACT_DELETE,    $urandom,     6'd63);
    send_item(ACT_DELETE,    $urandom,     POS_W'(CAPACITY - 1));

    phase = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) phase = $urandom_range(2);
      steady = (n >= 200 && n < 260);
      if (n == 300) drain_results();
      roll = $urandom_range(99);
      case (phase)
        0:       act = (roll < 80) ? ACT_INS_BACK : (roll < 90) ? ACT_DELETE : ACT_DUMP;
        1:       act = (roll < 75) ? ACT_DELETE : (roll < 88) ? ACT_INS_BACK : ACT_DUMP;
        default: act = (roll < 42) ? ACT_INS_BACK : (roll < 85) ? ACT_DELETE : ACT_DUMP;
      endcase
      if (act == ACT_INS_BACK && $urandom_range(1)) act = ACT_INS_FRONT;
      if (act == ACT_DELETE) send_item(act, $urandom, pick_position());
      else if (act == ACT_DUMP) send_item(act, $urandom, POS_W'($urandom));
      else send_item(act, pick_value(), POS_W'($urandom));
    end
    steady = 1'b0;

    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_ordered_list_buffer: PASS");
    end else begin
      $display("tb_ordered_list_buffer: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_ordered_list_buffer: FAIL");
    $finish;
  end

endmodule
